// ----- rtl/core/frc_pkg.sv -----
// shared types and constants for the frame receiver with checksum
`default_nettype none

package frc_pkg;

   // frame sync bytes and nibble mask
   localparam logic [7:0] HDR_FIRST   = 8'hEA;
   localparam logic [7:0] HDR_SECOND  = 8'hAF;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 12;
   localparam int CTRL_W    = 16;
   localparam int SUM_W     = 16;
   localparam int RSP_DATA_W = 64;

   // result kinds carried on tuser
   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_FRAME   = 1'b1;

   // receive phases
   typedef enum logic [3:0] {
      PH_HUNT     = 4'd0,
      PH_SYNC2    = 4'd1,
      PH_CTRL_HI  = 4'd2,
      PH_CTRL_LO  = 4'd3,
      PH_COMMAND  = 4'd4,
      PH_LEN_HI   = 4'd5,
      PH_LEN_LO   = 4'd6,
      PH_PAYLOAD  = 4'd7,
      PH_CHECK_HI = 4'd8,
      PH_CHECK_LO = 4'd9
   } phase_type;

endpackage

`default_nettype wire

// ----- rtl/core/frame_receiver_checksum.sv -----
// frame receiver top level: header hunt, field capture, payload stream and checksum test
//
// usage
//   req channel: one received serial byte per request on req_tdata
//   rsp channel: one result per payload byte, and one per frame whose check
//   matches; rsp_tuser gives the kind (0 payload byte, 1 frame accepted)
//   csr port: csr_wr_en writes payload_buffer_length from csr_wr_data; the user
//   must do so only while the block is idle, which the block does not enforce
// timing
//   a result appears on rsp in the cycle after the request that causes it;
//   one request is taken every cycle while no result waits or rsp_tready is high,
//   set by the single result register that each byte's phase step writes
// reset
//   synchronous, active high: phase returns to hunting for the first header
//   byte, the result register empties, payload_buffer_length becomes 256
// back-pressure
//   while a result waits and rsp_tready is low, req_tready drops; when the
//   result is taken in the same cycle a new request is accepted alongside
// bytes that cause no result are still taken and may move the receiver on by one phase
`default_nettype none

module frame_receiver_checksum
   import frc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,   // [7:0] data_byte
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] payload_byte, [19:8] payload_index, [20] within_buffer,
   // [36:21] frame_control, [44:37] command, [56:45] payload_length, [63:57] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,   // [0] result_kind
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [LEN_W-1:0]      csr_wr_data  // payload_buffer_length
);

   localparam int PAD_W = RSP_DATA_W - (BYTE_W + LEN_W + 1 + CTRL_W + BYTE_W + LEN_W);

   // receiver state
   phase_type           phase_ff, phase_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [BYTE_W-1:0]   check_hi_ff, check_hi_in;
   logic [CTRL_W-1:0]   control_ff, control_in;
   logic [BYTE_W-1:0]   command_ff, command_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [LEN_W-1:0]    count_ff, count_in;
   logic [LEN_W-1:0]    buf_len_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_kind_ff, rsp_kind_in;

   // per-request working values
   logic                  req_fire;
   logic                  emit;
   logic                  emit_kind;
   logic [BYTE_W-1:0]     b;
   logic [SUM_W-1:0]      sum_plus;
   logic [SUM_W-1:0]      check_word;
   logic [LEN_W-1:0]      count_next;
   logic [LEN_W-1:0]      length_full;

   // the result register frees up in the cycle it is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign b           = req_tdata;
   assign sum_plus    = sum_ff + {{(SUM_W-BYTE_W){1'b0}}, b};
   assign check_word  = {check_hi_ff, b};
   assign count_next  = count_ff + {{(LEN_W-1){1'b0}}, 1'b1};
   assign length_full = {length_ff[LEN_W-1:4], b[3:0] & NIBBLE_MASK};

   // phase step for the byte being accepted
   always_comb begin
      phase_in    = phase_ff;
      sum_in      = sum_ff;
      check_hi_in = check_hi_ff;
      control_in  = control_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      emit        = 1'b0;
      emit_kind   = RESULT_PAYLOAD;
      rsp_data_in = '0;

      if (req_fire) begin
         case (phase_ff)
            PH_SYNC2: begin
               if (b == HDR_SECOND) begin
                  sum_in   = sum_plus;
                  phase_in = PH_CTRL_HI;
               end else if (b == HDR_FIRST) begin
                  // repeated first header byte restarts the sum
                  sum_in = {{(SUM_W-BYTE_W){1'b0}}, HDR_FIRST};
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CTRL_HI: begin
               control_in = {b, control_ff[BYTE_W-1:0]};
               sum_in     = sum_plus;
               phase_in   = PH_CTRL_LO;
            end
            PH_CTRL_LO: begin
               control_in = {control_ff[CTRL_W-1:BYTE_W], b};
               sum_in     = sum_plus;
               phase_in   = PH_COMMAND;
            end
            PH_COMMAND: begin
               command_in = b;
               sum_in     = sum_plus;
               phase_in   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in = {b, 4'h0};
               sum_in    = sum_plus;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (b[7:4] != (b[3:0] & NIBBLE_MASK)) begin
                  phase_in = PH_HUNT;
               end else begin
                  length_in = length_full;
                  sum_in    = sum_plus;
                  count_in  = '0;
                  phase_in  = (length_full == '0) ? PH_CHECK_HI : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               emit        = 1'b1;
               emit_kind   = RESULT_PAYLOAD;
               rsp_data_in = {{PAD_W{1'b0}}, {LEN_W{1'b0}}, {BYTE_W{1'b0}},
                              {CTRL_W{1'b0}}, (count_ff < buf_len_ff), count_ff, b};
               sum_in      = sum_plus;
               count_in    = count_next;
               if (count_next == length_ff) begin
                  phase_in = PH_CHECK_HI;
               end
            end
            PH_CHECK_HI: begin
               check_hi_in = b;
               phase_in    = PH_CHECK_LO;
            end
            PH_CHECK_LO: begin
               if (sum_ff == ~check_word) begin
                  emit        = 1'b1;
                  emit_kind   = RESULT_FRAME;
                  rsp_data_in = {{PAD_W{1'b0}}, length_ff, command_ff, control_ff,
                                 1'b0, {LEN_W{1'b0}}, {BYTE_W{1'b0}}};
               end
               phase_in = PH_HUNT;
            end
            default: begin
               // hunting for the first header byte
               phase_in = PH_HUNT;
               if (b == HDR_FIRST) begin
                  sum_in   = {{(SUM_W-BYTE_W){1'b0}}, HDR_FIRST};
                  phase_in = PH_SYNC2;
               end
            end
         endcase
      end
   end

   // result register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (req_fire) begin
         rsp_valid_in = emit;
         rsp_kind_in  = emit_kind;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         sum_ff       <= '0;
         check_hi_ff  <= '0;
         control_ff   <= '0;
         command_ff   <= '0;
         length_ff    <= '0;
         count_ff     <= '0;
         buf_len_ff   <= LEN_W'(256);
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= RESULT_PAYLOAD;
      end else begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         check_hi_ff  <= check_hi_in;
         control_ff   <= control_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_kind_ff  <= rsp_kind_in;
         if (csr_wr_en) begin
            buf_len_ff <= csr_wr_data;
         end
      end
   end

   // payload of the result register, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

`ifndef SYNTHESIS
   // a waiting result that is not taken must hold off new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

   // the check low byte always ends the frame
   a_check_ends: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_CHECK_LO) |=> (phase_ff == PH_HUNT))
      else $error("frame did not end after check");

   // only payload and check low phases produce results
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff != PH_PAYLOAD && phase_ff != PH_CHECK_LO) |=> !rsp_valid_ff)
      else $error("result from a header or field byte");

   // payload counter stays below the frame length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (count_ff < length_ff))
      else $error("payload count overran length");
`endif

endmodule

`default_nettype wire

// ----- bench/frame_receiver_checksum_tb.sv -----
// self-checking bench for the frame receiver: byte requests in, payload and frame results checked
module frame_receiver_checksum_tb;
   import frc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // no request or result taken for this many cycles means the block is stuck
   localparam int STALL_LIMIT    = 4000;
   // long receiver hold-off used to fill the result register and stall requests
   localparam int HOLD_OFF_LEN   = 400;
   // spare margin before a register write and at the end, after the results drain
   localparam int DRAIN_CYCLES   = 8;
   // request counts at which the random part and the quiet tail stop
   localparam int RANDOM_UNTIL   = 1500;
   localparam int TAIL_UNTIL     = 1650;
   localparam int REPORT_LIMIT   = 10;

   // ways a frame can be spoilt on purpose
   typedef enum int {
      FAULT_NONE,
      FAULT_SYNC,
      FAULT_NIBBLE,
      FAULT_CHECK
   } frame_fault_type;

   // one predicted result, same fields as the rsp channel
   typedef struct packed {
      logic               kind;
      logic [BYTE_W-1:0]  data;
      logic [LEN_W-1:0]   index;
      logic               in_buffer;
      logic [CTRL_W-1:0]  ctrl;
      logic [BYTE_W-1:0]  cmd;
      logic [LEN_W-1:0]   length;
   } rx_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;     // [7:0] data_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [7:0] payload_byte, [19:8] payload_index, [20] within_buffer,
   // [36:21] frame_control, [44:37] command, [56:45] payload_length, [63:57] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;     // [0] result_kind
   logic                  csr_wr_en;
   logic [LEN_W-1:0]      csr_wr_data;   // payload_buffer_length

   // receiver state as the bench sees it
   phase_type             rx_phase;
   logic [SUM_W-1:0]      rx_sum;
   logic [SUM_W-1:0]      rx_check;
   logic [CTRL_W-1:0]     rx_ctrl;
   logic [BYTE_W-1:0]     rx_cmd;
   logic [LEN_W-1:0]      rx_len;
   logic [LEN_W-1:0]      rx_count;
   logic [LEN_W-1:0]      buffer_length;

   rx_result_type         awaited_results[$];
   int                    bytes_taken;
   int                    mismatches;
   int                    quiet_cycles;
   int                    hold_off_cycles;
   bit                    idle_on;
   bit                    stalls_on;

   frame_receiver_checksum u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // advance the bench copy of the receiver by one accepted byte
   // and queue the result that byte should produce, if any
   task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
      rx_result_type r;
      r = '0;
      case (rx_phase)
         PH_SYNC2: begin
            if (b == HDR_SECOND) begin
               rx_sum   = rx_sum + b;
               rx_phase = PH_CTRL_HI;
            end else if (b == HDR_FIRST) begin
               // repeated first sync byte: sum starts over, still waiting for the second
               rx_sum = {8'h00, HDR_FIRST};
            end else begin
               rx_phase = PH_HUNT;
            end
         end
         PH_CTRL_HI: begin
            rx_ctrl  = {b, 8'h00};
            rx_sum   = rx_sum + b;
            rx_phase = PH_CTRL_LO;
         end
         PH_CTRL_LO: begin
            rx_ctrl[7:0] = b;
            rx_sum       = rx_sum + b;
            rx_phase     = PH_COMMAND;
         end
         PH_COMMAND: begin
            rx_cmd   = b;
            rx_sum   = rx_sum + b;
            rx_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            rx_len   = {b, 4'h0};
            rx_sum   = rx_sum + b;
            rx_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            // nibbles disagree: frame dropped, this byte is not looked at as a sync byte
            if (b[7:4] != (b[3:0] & NIBBLE_MASK)) begin
               rx_phase = PH_HUNT;
            end else begin
               rx_len[3:0] = b[3:0];
               rx_sum      = rx_sum + b;
               rx_count    = '0;
               rx_phase    = (rx_len == '0) ? PH_CHECK_HI : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            r.kind      = RESULT_PAYLOAD;
            r.data      = b;
            r.index     = rx_count;
            r.in_buffer = (rx_count < buffer_length);
            awaited_results.push_back(r);
            rx_sum   = rx_sum + b;
            rx_count = rx_count + 1'b1;
            if (rx_count == rx_len) rx_phase = PH_CHECK_HI;
         end
         PH_CHECK_HI: begin
            rx_check = {b, 8'h00};
            rx_phase = PH_CHECK_LO;
         end
         PH_CHECK_LO: begin
            rx_check[7:0] = b;
            // a bad check drops the frame without a result
            if (rx_sum == ~rx_check) begin
               r.kind   = RESULT_FRAME;
               r.ctrl   = rx_ctrl;
               r.cmd    = rx_cmd;
               r.length = rx_len;
               awaited_results.push_back(r);
            end
            rx_phase = PH_HUNT;
         end
         default: begin
            // hunting, and any phase the receiver never uses
            rx_phase = PH_HUNT;
            if (b == HDR_FIRST) begin
               rx_sum   = {8'h00, HDR_FIRST};
               rx_phase = PH_SYNC2;
            end
         end
      endcase
   endtask

   // offer one byte, sometimes after a random gap, and wait for the request to be taken
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      track_rx_byte(b);
      bytes_taken++;
   endtask

   // build one frame, good or spoilt, and send it byte by byte
   task automatic send_frame(input logic [CTRL_W-1:0] ctrl, input logic [BYTE_W-1:0] cmd,
                             input logic [LEN_W-1:0] len, input int extra_sync,
                             input frame_fault_type fault);
      logic [BYTE_W-1:0] frame_q[$];
      logic [BYTE_W-1:0] b;
      logic [SUM_W-1:0]  sum;
      frame_q.push_back(HDR_FIRST);
      if (fault == FAULT_SYNC) begin
         do b = BYTE_W'($urandom_range(0, 255)); while (b == HDR_FIRST || b == HDR_SECOND);
         frame_q.push_back(b);
      end else begin
         frame_q.push_back(HDR_SECOND);
         frame_q.push_back(ctrl[15:8]);
         frame_q.push_back(ctrl[7:0]);
         frame_q.push_back(cmd);
         frame_q.push_back(len[11:4]);
         if (fault == FAULT_NIBBLE) begin
            do b = BYTE_W'($urandom_range(0, 255)); while (b[7:4] == b[3:0]);
            frame_q.push_back(b);
         end else begin
            frame_q.push_back({len[3:0], len[3:0]});
            repeat (len) frame_q.push_back(BYTE_W'($urandom_range(0, 255)));
            sum = '0;
            foreach (frame_q[i]) sum = sum + frame_q[i];
            sum = ~sum;
            if (fault == FAULT_CHECK) sum = sum ^ SUM_W'($urandom_range(1, 65535));
            frame_q.push_back(sum[15:8]);
            frame_q.push_back(sum[7:0]);
         end
      end
      // extra sync bytes in front do not enter the sum
      repeat (extra_sync) send_byte(HDR_FIRST);
      foreach (frame_q[i]) send_byte(frame_q[i]);
   endtask

   // mostly short payloads, now and then a long one
   function automatic logic [LEN_W-1:0] pick_length();
      if ($urandom_range(0, 19) == 0) return LEN_W'($urandom_range(100, 300));
      return LEN_W'($urandom_range(0, 16));
   endfunction

   function automatic logic [CTRL_W-1:0] rand_ctrl();
      return CTRL_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [BYTE_W-1:0] rand_cmd();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // drop the request line and let every awaited result come out
   task automatic wait_quiescent();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_buffer_length(input logic [LEN_W-1:0] value);
      wait_quiescent();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      buffer_length = value;
   endtask

   // sync hunt: a wrong second byte, then a zero-length frame behind a repeated first byte
   task automatic test_header_sync();
      send_byte(HDR_FIRST);
      send_byte(8'h55);
      send_frame(16'hFFFF, 8'h00, 12'd0, 1, FAULT_NONE);
   endtask

   // length nibbles disagree; the offending byte is a first sync byte that must be ignored
   task automatic test_length_field();
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
   endtask

   // a frame whose check does not match is dropped after its payload
   task automatic test_check_field();
      send_frame(16'hA5C3, 8'h3C, 12'd1, 0, FAULT_CHECK);
   endtask

   // buffer flag at both extremes, at a small boundary and across the reset value
   task automatic test_buffer_length();
      write_buffer_length(12'd0);
      send_frame(rand_ctrl(), rand_cmd(), 12'd5, 0, FAULT_NONE);
      write_buffer_length(12'hFFF);
      send_frame(rand_ctrl(), rand_cmd(), 12'd10, 0, FAULT_NONE);
      write_buffer_length(12'd3);
      send_frame(rand_ctrl(), rand_cmd(), 12'd6, 0, FAULT_NONE);
      write_buffer_length(12'd256);
      send_frame(rand_ctrl(), rand_cmd(), 12'd300, 0, FAULT_NONE);
   endtask

   // receiver holds off while a long payload keeps coming, so requests back up
   task automatic test_backpressure();
      hold_off_cycles = HOLD_OFF_LEN;
      send_frame(rand_ctrl(), rand_cmd(), 12'd40, 0, FAULT_NONE);
   endtask

   // mostly good frames with random content, some spoilt ones, noise and register changes
   task automatic test_random_traffic();
      int pick;
      logic [BYTE_W-1:0] b;
      while (bytes_taken < RANDOM_UNTIL) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(rand_ctrl(), rand_cmd(), pick_length(),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0, FAULT_NONE);
         end else if (pick < 78) begin
            send_frame(rand_ctrl(), rand_cmd(), pick_length(), 0, FAULT_CHECK);
         end else if (pick < 84) begin
            send_frame(rand_ctrl(), rand_cmd(), 12'd0, 0, FAULT_NIBBLE);
         end else if (pick < 89) begin
            send_frame(16'h0000, 8'h00, 12'd0, 0, FAULT_SYNC);
         end else if (pick < 97) begin
            // line noise while hunting, kept off the first sync byte
            repeat ($urandom_range(1, 4)) begin
               do b = BYTE_W'($urandom_range(0, 255)); while (b == HDR_FIRST);
               send_byte(b);
            end
         end else if ($urandom_range(0, 3) == 0) begin
            write_buffer_length(LEN_W'($urandom_range(0, 4095)));
         end else begin
            write_buffer_length(LEN_W'($urandom_range(0, 20)));
         end
      end
   endtask

   // last stretch with no gaps and no stalls on either side
   task automatic test_quiet_tail();
      idle_on   = 1'b0;
      stalls_on = 1'b0;
      while (bytes_taken < TAIL_UNTIL)
         send_frame(rand_ctrl(), rand_cmd(), LEN_W'($urandom_range(0, 16)), 0, FAULT_NONE);
   endtask

   task automatic flag_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
   endtask

   // result sink: random stalls, plus the long hold-off when one is asked for
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare every taken result with the oldest one awaited
   always @(posedge clock) begin : check_results
      rx_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            flag_field("unexpected result", '0, rsp_tdata);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser !== want.kind)
               flag_field("result_kind", 64'(want.kind), 64'(rsp_tuser));
            if (rsp_tdata[7:0] !== want.data)
               flag_field("payload_byte", 64'(want.data), 64'(rsp_tdata[7:0]));
            if (rsp_tdata[19:8] !== want.index)
               flag_field("payload_index", 64'(want.index), 64'(rsp_tdata[19:8]));
            if (rsp_tdata[20] !== want.in_buffer)
               flag_field("within_buffer", 64'(want.in_buffer), 64'(rsp_tdata[20]));
            if (rsp_tdata[36:21] !== want.ctrl)
               flag_field("frame_control", 64'(want.ctrl), 64'(rsp_tdata[36:21]));
            if (rsp_tdata[44:37] !== want.cmd)
               flag_field("command", 64'(want.cmd), 64'(rsp_tdata[44:37]));
            if (rsp_tdata[56:45] !== want.length)
               flag_field("payload_length", 64'(want.length), 64'(rsp_tdata[56:45]));
            if (rsp_tdata[63:57] !== '0)
               flag_field("padding", '0, 64'(rsp_tdata[63:57]));
         end
      end
   end

   // watchdog: too long with neither a request nor a result taken
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      // every input known from time zero
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      quiet_cycles    = 0;
      hold_off_cycles = 0;
      bytes_taken     = 0;
      mismatches      = 0;
      idle_on         = 1'b1;
      stalls_on       = 1'b1;
      // bench receiver copy starts as the block does out of reset
      rx_phase      = PH_HUNT;
      rx_sum        = '0;
      rx_check      = '0;
      rx_ctrl       = '0;
      rx_cmd        = '0;
      rx_len        = '0;
      rx_count      = '0;
      buffer_length = 12'd256;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_header_sync();
      test_length_field();
      test_check_field();
      test_buffer_length();
      test_backpressure();
      test_random_traffic();
      test_quiet_tail();

      // everything sent: wait for the last results, then let the drain margin pass
      wait_quiescent();
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
